FILE: design/key_event_detector_defines.svh
// assertion macros for the key event detector
// expects clk and rst_n in the scope where a macro is used
`ifndef KEY_EVENT_DETECTOR_DEFINES_SVH
`define KEY_EVENT_DETECTOR_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define KED_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked while out of reset
`define KED_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/ked_pkg.sv
// shared types and constants for the key event detector
// no dependencies
package ked_pkg;

  localparam int NUM_KEYS = 8;
  localparam int KEY_W    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int LEVEL_W  = 8;
  localparam int IDX_W    = 3;
  localparam int SEL_W    = 3;
  localparam int FLAG_W   = 7;
  localparam int TIMER_W  = 16;
  localparam int DIV_W    = 5;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_CHECK = 1'b1;

  localparam logic [SEL_W-1:0] FLAG_HOLD   = 3'd0;
  localparam logic [SEL_W-1:0] FLAG_DOWN   = 3'd1;
  localparam logic [SEL_W-1:0] FLAG_UP     = 3'd2;
  localparam logic [SEL_W-1:0] FLAG_SINGLE = 3'd3;
  localparam logic [SEL_W-1:0] FLAG_DOUBLE = 3'd4;
  localparam logic [SEL_W-1:0] FLAG_LONG   = 3'd5;
  localparam logic [SEL_W-1:0] FLAG_REPEAT = 3'd6;
  localparam logic [SEL_W-1:0] FLAG_NONE   = 3'd7;

  localparam logic [1:0] REG_LONG   = 2'd0;
  localparam logic [1:0] REG_DOUBLE = 2'd1;
  localparam logic [1:0] REG_REPEAT = 2'd2;
  localparam logic [1:0] REG_DIV    = 2'd3;

  localparam logic [TIMER_W-1:0] LONG_TIME_RST   = 16'd3000;
  localparam logic [TIMER_W-1:0] DOUBLE_TIME_RST = 16'd200;
  localparam logic [TIMER_W-1:0] REPEAT_TIME_RST = 16'd100;
  localparam logic [DIV_W-1:0]   SAMPLE_DIV_RST  = 5'd20;

  typedef enum logic [2:0] {
    KS_IDLE    = 3'd0,
    KS_PRESSED = 3'd1,
    KS_WAIT    = 3'd2,
    KS_SECOND  = 3'd3,
    KS_REPEAT  = 3'd4
  } key_state_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_SCAN,
    CS_CHECK
  } ctrl_state_t;

  typedef struct packed {
    logic [TIMER_W-1:0] long_time;
    logic [TIMER_W-1:0] double_time;
    logic [TIMER_W-1:0] repeat_time;
    logic [DIV_W-1:0]   sample_divider;
  } cfg_t;

  typedef struct packed {
    logic             load;
    logic             step;
    logic             check;
    logic [KEY_W-1:0] key;
  } dp_cmd_t;

  typedef struct packed {
    logic slot_free;
  } dp_status_t;

endpackage

FILE: design/ked_in_if.sv
// input channel of the key event detector: valid/ready plus command payload
// depends on ked_pkg
interface ked_in_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [ked_pkg::LEVEL_W-1:0]  key_levels;
  logic [ked_pkg::IDX_W-1:0]    key_index;
  logic [ked_pkg::SEL_W-1:0]    flag_select;

  modport source (output valid, command, key_levels, key_index, flag_select, input ready);
  modport sink   (input valid, command, key_levels, key_index, flag_select, output ready);
endinterface

FILE: design/ked_out_if.sv
// result channel of the key event detector: valid/ready plus flag bit
// no dependencies
interface ked_out_if;
  logic valid;
  logic ready;
  logic flag_was_set;

  modport source (output valid, flag_was_set, input ready);
  modport sink   (input valid, flag_was_set, output ready);
endinterface

FILE: design/ked_regs.sv
// apb-style configuration registers of the key event detector
// depends on ked_pkg
module ked_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [ked_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [ked_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [ked_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                        cfg_pready,
  output ked_pkg::cfg_t               cfg
);

  ked_pkg::cfg_t cfg_r;
  logic          wr_en;
  logic [1:0]    reg_sel;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_sel    = cfg_paddr[3:2];
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_time      <= ked_pkg::LONG_TIME_RST;
      cfg_r.double_time    <= ked_pkg::DOUBLE_TIME_RST;
      cfg_r.repeat_time    <= ked_pkg::REPEAT_TIME_RST;
      cfg_r.sample_divider <= ked_pkg::SAMPLE_DIV_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        ked_pkg::REG_LONG:   cfg_r.long_time      <= cfg_pwdata[ked_pkg::TIMER_W-1:0];
        ked_pkg::REG_DOUBLE: cfg_r.double_time    <= cfg_pwdata[ked_pkg::TIMER_W-1:0];
        ked_pkg::REG_REPEAT: cfg_r.repeat_time    <= cfg_pwdata[ked_pkg::TIMER_W-1:0];
        ked_pkg::REG_DIV:    cfg_r.sample_divider <= cfg_pwdata[ked_pkg::DIV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      ked_pkg::REG_LONG:   cfg_prdata = ked_pkg::DATA_W'(cfg_r.long_time);
      ked_pkg::REG_DOUBLE: cfg_prdata = ked_pkg::DATA_W'(cfg_r.double_time);
      ked_pkg::REG_REPEAT: cfg_prdata = ked_pkg::DATA_W'(cfg_r.repeat_time);
      ked_pkg::REG_DIV:    cfg_prdata = ked_pkg::DATA_W'(cfg_r.sample_divider);
      default:             cfg_prdata = '0;
    endcase
  end

endmodule

FILE: design/ked_ctrl.sv
// controller of the key event detector: accepts items, walks the keys on a tick,
// issues the check once the result register is free; depends on ked_pkg
module ked_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_command,
  output logic                 in_ready,
  input  ked_pkg::dp_status_t  status,
  output ked_pkg::dp_cmd_t     cmd
);

  ked_pkg::ctrl_state_t         state_r, state_nxt;
  logic [ked_pkg::KEY_W-1:0]    key_cnt_r, key_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ked_pkg::CS_IDLE;
      key_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      key_cnt_r <= key_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    key_cnt_nxt = key_cnt_r;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.key     = key_cnt_r;
    unique case (state_r)
      ked_pkg::CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load    = 1'b1;
          key_cnt_nxt = '0;
          state_nxt   = (in_command == ked_pkg::CMD_CHECK) ? ked_pkg::CS_CHECK
                                                           : ked_pkg::CS_SCAN;
        end
      end
      ked_pkg::CS_SCAN: begin
        cmd.step = 1'b1;
        if (key_cnt_r == ked_pkg::KEY_W'(ked_pkg::NUM_KEYS - 1)) begin
          state_nxt = ked_pkg::CS_IDLE;
        end else begin
          key_cnt_nxt = key_cnt_r + 1'b1;
        end
      end
      ked_pkg::CS_CHECK: begin
        if (status.slot_free) begin
          cmd.check = 1'b1;
          state_nxt = ked_pkg::CS_IDLE;
        end
      end
      default: state_nxt = ked_pkg::CS_IDLE;
    endcase
  end

endmodule

FILE: design/ked_datapath.sv
// datapath of the key event detector: per-key level, state, timer and flags,
// one key updated per step, plus the result register; depends on ked_pkg
module ked_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ked_pkg::cfg_t               cfg,
  input  ked_pkg::dp_cmd_t            cmd,
  output ked_pkg::dp_status_t         status,
  input  logic                        in_command,
  input  logic [ked_pkg::LEVEL_W-1:0] in_key_levels,
  input  logic [ked_pkg::IDX_W-1:0]   in_key_index,
  input  logic [ked_pkg::SEL_W-1:0]   in_flag_select,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_flag_was_set
);

  localparam int NK = ked_pkg::NUM_KEYS;
  localparam int KW = ked_pkg::KEY_W;
  localparam int TW = ked_pkg::TIMER_W;
  localparam int FW = ked_pkg::FLAG_W;

  // per-key state
  logic                  cur_lvl_r [NK];
  ked_pkg::key_state_t   fsm_r     [NK];
  logic [TW-1:0]         timer_r   [NK];
  logic [FW-1:0]         flags_r   [NK];

  // latched item and tick bookkeeping
  logic [ked_pkg::LEVEL_W-1:0] levels_r;
  logic [ked_pkg::IDX_W-1:0]   key_idx_r;
  logic [ked_pkg::SEL_W-1:0]   flag_sel_r;
  logic [ked_pkg::DIV_W-1:0]   prescale_r;
  logic                        sample_r;
  logic                        out_valid_r;
  logic                        out_flag_r;

  logic [ked_pkg::DIV_W-1:0]   prescale_inc;
  logic                        sample_now;
  logic [KW-1:0]               chk_key;
  logic [KW-1:0]               rd_key;
  logic                        prev_lvl;
  logic                        lvl;
  ked_pkg::key_state_t         st;
  logic [TW-1:0]               tmr;
  logic [TW-1:0]               tmr_dec;
  logic [FW-1:0]               flg;
  logic                        cur_nxt;
  ked_pkg::key_state_t         st_nxt;
  logic [TW-1:0]               tmr_nxt;
  logic [FW-1:0]               flg_nxt;
  logic                        chk_ok;
  logic                        hit;
  logic [FW:0]                 flg_ext;
  logic [FW-1:0]               flg_clr;

  assign prescale_inc = prescale_r + 1'b1;
  assign sample_now   = (prescale_inc >= cfg.sample_divider);

  assign chk_key  = KW'(key_idx_r);
  assign rd_key   = cmd.check ? chk_key : cmd.key;
  assign prev_lvl = cur_lvl_r[rd_key];
  assign st       = fsm_r[rd_key];
  assign tmr      = timer_r[rd_key];
  assign flg      = flags_r[rd_key];
  assign tmr_dec  = (tmr != '0) ? tmr - 1'b1 : tmr;
  // keys past the level word read as unpressed
  assign lvl      = (int'(rd_key) < ked_pkg::LEVEL_W) ? levels_r[3'(rd_key)] : 1'b0;

  always_comb begin
    cur_nxt = prev_lvl;
    st_nxt  = st;
    tmr_nxt = tmr_dec;
    flg_nxt = flg;
    if (sample_r) begin
      cur_nxt                     = lvl;
      flg_nxt[ked_pkg::FLAG_HOLD] = lvl;
      if (lvl && !prev_lvl) flg_nxt[ked_pkg::FLAG_DOWN] = 1'b1;
      if (!lvl && prev_lvl) flg_nxt[ked_pkg::FLAG_UP]   = 1'b1;
      unique case (st)
        ked_pkg::KS_IDLE: begin
          if (lvl) begin
            tmr_nxt = cfg.long_time;
            st_nxt  = ked_pkg::KS_PRESSED;
          end
        end
        ked_pkg::KS_PRESSED: begin
          if (!lvl) begin
            tmr_nxt = cfg.double_time;
            st_nxt  = ked_pkg::KS_WAIT;
          end else if (tmr_dec == '0) begin
            tmr_nxt                     = cfg.repeat_time;
            flg_nxt[ked_pkg::FLAG_LONG] = 1'b1;
            st_nxt                      = ked_pkg::KS_REPEAT;
          end
        end
        ked_pkg::KS_WAIT: begin
          if (tmr_dec == '0) begin
            flg_nxt[ked_pkg::FLAG_SINGLE] = 1'b1;
            st_nxt                        = ked_pkg::KS_IDLE;
          end else if (lvl) begin
            flg_nxt[ked_pkg::FLAG_DOUBLE] = 1'b1;
            st_nxt                        = ked_pkg::KS_SECOND;
          end
        end
        ked_pkg::KS_SECOND: begin
          if (!lvl) st_nxt = ked_pkg::KS_IDLE;
        end
        ked_pkg::KS_REPEAT: begin
          // release wins over an expired repeat interval
          if (!lvl) begin
            st_nxt = ked_pkg::KS_IDLE;
          end else if (tmr_dec == '0) begin
            tmr_nxt                       = cfg.repeat_time;
            flg_nxt[ked_pkg::FLAG_REPEAT] = 1'b1;
          end
        end
        default: st_nxt = ked_pkg::KS_IDLE;
      endcase
    end
  end

  // check path: hold is reported but never cleared
  assign chk_ok  = (int'(key_idx_r) < NK) && (flag_sel_r != ked_pkg::FLAG_NONE);
  assign flg_ext = {1'b0, flg};
  assign hit     = chk_ok && flg_ext[flag_sel_r];
  assign flg_clr = flg & ~FW'(1 << flag_sel_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NK; k++) begin
        cur_lvl_r[k] <= 1'b0;
        fsm_r[k]     <= ked_pkg::KS_IDLE;
        timer_r[k]   <= '0;
        flags_r[k]   <= '0;
      end
      prescale_r  <= '0;
      sample_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load && (in_command == ked_pkg::CMD_TICK)) begin
        sample_r   <= sample_now;
        prescale_r <= sample_now ? '0 : prescale_inc;
      end
      if (cmd.step) begin
        cur_lvl_r[rd_key] <= cur_nxt;
        fsm_r[rd_key]     <= st_nxt;
        timer_r[rd_key]   <= tmr_nxt;
        flags_r[rd_key]   <= flg_nxt;
      end else if (cmd.check && hit && (flag_sel_r != ked_pkg::FLAG_HOLD)) begin
        flags_r[rd_key] <= flg_clr;
      end
      if (cmd.check) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      levels_r   <= in_key_levels;
      key_idx_r  <= in_key_index;
      flag_sel_r <= in_flag_select;
    end
    if (cmd.check) begin
      out_flag_r <= hit;
    end
  end

  assign status.slot_free = !out_valid_r || out_ready;
  assign out_valid        = out_valid_r;
  assign out_flag_was_set = out_flag_r;

endmodule

FILE: design/key_event_detector.sv
// tick: the item is taken in the idle state, then the scan state updates one key a cycle
//   until all NUM_KEYS keys are done; only then is the next item taken
// check: the result is written to the output register from the check state once that
//   register is free, and the next item is taken after it; a held result stalls only the next check
// rst_n is synchronous: all key state and the prescaler clear, registers take defaults
module key_event_detector (
  input  logic                        clk,
  input  logic                        rst_n,
  ked_in_if.sink                      in,
  ked_out_if.source                   out,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [ked_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [ked_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [ked_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

`include "key_event_detector_defines.svh"

  ked_pkg::cfg_t       cfg;
  ked_pkg::dp_cmd_t    cmd;
  ked_pkg::dp_status_t status;

  ked_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  ked_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in.valid),
    .in_command (in.command),
    .in_ready   (in.ready),
    .status     (status),
    .cmd        (cmd)
  );

  ked_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .cmd              (cmd),
    .status           (status),
    .in_command       (in.command),
    .in_key_levels    (in.key_levels),
    .in_key_index     (in.key_index),
    .in_flag_select   (in.flag_select),
    .out_valid        (out.valid),
    .out_ready        (out.ready),
    .out_flag_was_set (out.flag_was_set)
  );

  // an accepted item always keeps the input closed for the following cycle
  `KED_ASSERT_NEXT(a_busy_after_transfer, in.valid && in.ready, !in.ready, "ready after transfer")
  // a check is only issued into a free result register
  `KED_ASSERT_NOW(a_check_slot_free, cmd.check, status.slot_free, "check into full slot")
  // a new result only appears right after a check
  `KED_ASSERT_NOW(a_result_from_check, $rose(out.valid), $past(cmd.check), "stray result")

endmodule

FILE: bench/key_event_detector_tb.sv
`timescale 1ns / 100ps
// self-checking bench for key_event_detector: drives ticks and flag checks with
// random idling on both channels and compares every returned flag bit
// depends on ked_pkg, ked_in_if, ked_out_if and the key_event_detector rtl
module key_event_detector_tb;
  import ked_pkg::*;

  localparam int  PHASES      = 8;
  localparam int  PHASE_ITEMS = 180;
  localparam int  DIR_ROWS    = 25;
  localparam int  DIR_CFG_AT  = 3;
  localparam int  SETTLE      = 12;
  localparam int  SHOWN_FAILS = 10;
  localparam time LIMIT_NS    = 5_000_000;

  localparam int RX_FREE   = 0;
  localparam int RX_RANDOM = 1;
  localparam int RX_RUNS   = 2;

  typedef struct packed {
    logic               cmd;
    logic [LEVEL_W-1:0] levels;
    logic [IDX_W-1:0]   idx;
    logic [SEL_W-1:0]   sel;
    logic               typed;
    logic               want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  ked_in_if  in_ch ();
  ked_out_if out_ch ();

  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [DATA_W-1:0] cfg_pwdata;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  key_event_detector dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in          (in_ch),
    .out         (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // detector state as the bench sees it
  logic [TIMER_W-1:0] long_cfg, double_cfg, repeat_cfg;
  logic [DIV_W-1:0]   div_cfg;
  logic [DIV_W-1:0]   m_prescale;
  logic [NUM_KEYS-1:0] m_level, m_level_prev;
  key_state_t         m_state [NUM_KEYS];
  logic [TIMER_W-1:0] m_timer [NUM_KEYS];
  logic [FLAG_W-1:0]  m_flags [NUM_KEYS];

  logic pending_flags [$];
  int   fail_count;

  // press pattern generator, one hold counter per key
  logic [NUM_KEYS-1:0] press_level;
  int                  press_left [NUM_KEYS];

  stim_row_t dir_rows [DIR_ROWS] = '{
    '{CMD_CHECK, 8'h00, 3'd0, FLAG_HOLD,   1'b1, 1'b0},
    '{CMD_CHECK, 8'h00, 3'd7, FLAG_REPEAT, 1'b1, 1'b0},
    '{CMD_CHECK, 8'h00, 3'd3, FLAG_NONE,   1'b1, 1'b0},
    '{CMD_TICK,  8'hFF, 3'd0, FLAG_HOLD,   1'b0, 1'b0},
    '{CMD_CHECK, 8'h00, 3'd0, FLAG_HOLD,   1'b1, 1'b1},
    '{CMD_CHECK, 8'h00, 3'd7, FLAG_DOWN,   1'b1, 1'b1},
    '{CMD_CHECK, 8'h00, 3'd7, FLAG_DOWN,   1'b1, 1'b0},
    '{CMD_TICK,  8'hFF, 3'd0, FLAG_HOLD,   1'b0, 1'b0},
    '{CMD_TICK,  8'hFF, 3'd0, FLAG_HOLD,   1'b0, 1'b0},
    '{CMD_TICK,  8'hFF, 3'd0, FLAG_HOLD,   1'b0, 1'b0},
    '{CMD_CHECK, 8'h00, 3'd3, FLAG_LONG,   1'b0, 1'b0},
    '{CMD_TICK,  8'hFF, 3'd0, FLAG_HOLD,   1'b0, 1'b0},
    '{CMD_CHECK, 8'h00, 3'd5, FLAG_REPEAT, 1'b0, 1'b0},
    // release while repeating with the timer running out
    '{CMD_TICK,  8'h00, 3'd0, FLAG_HOLD,   1'b0, 1'b0},
    '{CMD_CHECK, 8'h00, 3'd5, FLAG_REPEAT, 1'b0, 1'b0},
    '{CMD_CHECK, 8'h00, 3'd2, FLAG_UP,     1'b0, 1'b0},
    '{CMD_TICK,  8'h0F, 3'd0, FLAG_HOLD,   1'b0, 1'b0},
    '{CMD_TICK,  8'h00, 3'd0, FLAG_HOLD,   1'b0, 1'b0},
    '{CMD_TICK,  8'h01, 3'd0, FLAG_HOLD,   1'b0, 1'b0},
    '{CMD_TICK,  8'h00, 3'd0, FLAG_HOLD,   1'b0, 1'b0},
    '{CMD_CHECK, 8'h00, 3'd0, FLAG_DOUBLE, 1'b0, 1'b0},
    '{CMD_CHECK, 8'h00, 3'd1, FLAG_SINGLE, 1'b0, 1'b0},
    '{CMD_CHECK, 8'h00, 3'd7, FLAG_NONE,   1'b1, 1'b0},
    '{CMD_CHECK, 8'h00, 3'd0, FLAG_HOLD,   1'b0, 1'b0},
    '{CMD_TICK,  8'hAA, 3'd0, FLAG_HOLD,   1'b0, 1'b0}
  };

  function automatic void detector_reset();
    long_cfg     = LONG_TIME_RST;
    double_cfg   = DOUBLE_TIME_RST;
    repeat_cfg   = REPEAT_TIME_RST;
    div_cfg      = SAMPLE_DIV_RST;
    m_prescale   = '0;
    m_level      = '0;
    m_level_prev = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      m_state[k] = KS_IDLE;
      m_timer[k] = '0;
      m_flags[k] = '0;
    end
  endfunction

  function automatic void sample_one_key(input int k, input logic lvl);
    logic [FLAG_W-1:0] f;
    f = m_flags[k];
    m_level_prev[k] = m_level[k];
    m_level[k] = lvl;
    f[FLAG_HOLD] = lvl;
    if (lvl && !m_level_prev[k]) f[FLAG_DOWN] = 1'b1;
    if (!lvl && m_level_prev[k]) f[FLAG_UP] = 1'b1;
    case (m_state[k])
      KS_IDLE: begin
        if (lvl) begin
          m_timer[k] = long_cfg;
          m_state[k] = KS_PRESSED;
        end
      end
      KS_PRESSED: begin
        if (!lvl) begin
          m_timer[k] = double_cfg;
          m_state[k] = KS_WAIT;
        end else if (m_timer[k] == '0) begin
          m_timer[k] = repeat_cfg;
          f[FLAG_LONG] = 1'b1;
          m_state[k] = KS_REPEAT;
        end
      end
      KS_WAIT: begin
        if (m_timer[k] == '0) begin
          f[FLAG_SINGLE] = 1'b1;
          m_state[k] = KS_IDLE;
        end else if (lvl) begin
          f[FLAG_DOUBLE] = 1'b1;
          m_state[k] = KS_SECOND;
        end
      end
      KS_SECOND: begin
        if (!lvl) m_state[k] = KS_IDLE;
      end
      KS_REPEAT: begin
        // a release wins over an expiring timer
        if (!lvl) begin
          m_state[k] = KS_IDLE;
        end else if (m_timer[k] == '0) begin
          m_timer[k] = repeat_cfg;
          f[FLAG_REPEAT] = 1'b1;
        end
      end
      default: m_state[k] = KS_IDLE;
    endcase
    m_flags[k] = f;
  endfunction

  function automatic void detector_tick(input logic [LEVEL_W-1:0] levels);
    for (int k = 0; k < NUM_KEYS; k++)
      if (m_timer[k] != '0) m_timer[k] = m_timer[k] - 1'b1;
    m_prescale = m_prescale + 1'b1;
    if (m_prescale >= div_cfg) begin
      m_prescale = '0;
      for (int k = 0; k < NUM_KEYS; k++)
        sample_one_key(k, (k < LEVEL_W) ? levels[k] : 1'b0);
    end
  endfunction

  function automatic logic detector_check(input logic [IDX_W-1:0] idx,
                                          input logic [SEL_W-1:0] sel);
    logic hit;
    hit = 1'b0;
    if (int'(idx) < NUM_KEYS && sel != FLAG_NONE) begin
      if (m_flags[idx][sel]) begin
        hit = 1'b1;
        // hold follows the level and is never cleared by a check
        if (sel != FLAG_HOLD) m_flags[idx][sel] = 1'b0;
      end
    end
    return hit;
  endfunction

  // hold time in ticks for the level a key has just taken
  function automatic int pick_hold(input logic pressed);
    int scale, lt, dt, rt, s;
    scale = (div_cfg == '0) ? 1 : int'(div_cfg);
    lt = (long_cfg > 40) ? 40 : int'(long_cfg);
    dt = (double_cfg > 20) ? 20 : int'(double_cfg);
    rt = (repeat_cfg > 10) ? 10 : int'(repeat_cfg);
    if (pressed) begin
      case ($urandom_range(0, 2))
        0: s = $urandom_range(1, 2);
        1: s = $urandom_range(1, lt + 1);
        default: s = lt + $urandom_range(1, 3 * rt + 2);
      endcase
    end else begin
      if ($urandom_range(0, 1) == 0) s = $urandom_range(1, dt + 1);
      else s = dt + $urandom_range(1, 8);
    end
    return s * scale;
  endfunction

  function automatic logic [LEVEL_W-1:0] next_levels();
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (press_left[k] == 0) begin
        press_level[k] = !press_level[k];
        press_left[k] = pick_hold(press_level[k]);
      end
      press_left[k]--;
    end
    return press_level;
  endfunction

  function automatic void note_fail(input string what, input logic want, input logic got);
    fail_count++;
    if (fail_count <= SHOWN_FAILS)
      $display("mismatch at %0t: %s, expected %0d got %0d", $time, what, want, got);
  endfunction

  task automatic send_item(input logic cmd, input logic [LEVEL_W-1:0] lv,
                           input logic [IDX_W-1:0] idx, input logic [SEL_W-1:0] sel,
                           input logic typed, input logic typed_val);
    logic hit;
    in_ch.valid       <= 1'b1;
    in_ch.command     <= cmd;
    in_ch.key_levels  <= lv;
    in_ch.key_index   <= idx;
    in_ch.flag_select <= sel;
    do @(posedge clk); while (!in_ch.ready);
    if (cmd == CMD_TICK) begin
      detector_tick(lv);
    end else begin
      hit = detector_check(idx, sel);
      pending_flags.push_back(typed ? typed_val : hit);
    end
  endtask

  // stop sending, let every pending flag come back, then let a tick scan finish
  task automatic wait_results_idle();
    in_ch.valid <= 1'b0;
    while (pending_flags.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [TIMER_W-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= DATA_W'(val);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_LONG:   long_cfg = val;
      REG_DOUBLE: double_cfg = val;
      REG_REPEAT: repeat_cfg = val;
      REG_DIV:    div_cfg = val[DIV_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_cfg(input logic [TIMER_W-1:0] lt, input logic [TIMER_W-1:0] dt,
                           input logic [TIMER_W-1:0] rt, input logic [DIV_W-1:0] dv);
    wait_results_idle();
    write_reg(REG_LONG, lt);
    write_reg(REG_DOUBLE, dt);
    write_reg(REG_REPEAT, rt);
    write_reg(REG_DIV, TIMER_W'(dv));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("TB_ERROR");
    $finish;
  end

  // receiver stall pattern: free running, coin flips, or runs of stalls
  initial begin
    int   rx_mode, mode_left, run_left;
    logic rdy;
    rx_mode = RX_FREE;
    mode_left = 0;
    run_left = 0;
    rdy = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        rx_mode = $urandom_range(RX_FREE, RX_RUNS);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (rx_mode)
        RX_FREE:   rdy = 1'b1;
        RX_RANDOM: rdy = 1'($urandom_range(0, 1));
        default: begin
          if (run_left == 0) begin
            rdy = !rdy;
            run_left = rdy ? $urandom_range(1, 4) : $urandom_range(1, 12);
          end
          run_left--;
        end
      endcase
      out_ch.ready <= rdy;
    end
  end

  always @(posedge clk) begin : check_results
    logic want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_flags.size() == 0) begin
        note_fail("result transfer with nothing pending", 1'b0, out_ch.flag_was_set);
      end else begin
        want = pending_flags.pop_front();
        if (out_ch.flag_was_set !== want) note_fail("flag_was_set", want, out_ch.flag_was_set);
      end
    end
  end

  initial begin
    int                 burst_left, gap, pick;
    logic [TIMER_W-1:0] lt, dt, rt;
    logic [DIV_W-1:0]   dv;
    fail_count        = 0;
    burst_left        = 0;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.command     = CMD_TICK;
    in_ch.key_levels  = '0;
    in_ch.key_index   = '0;
    in_ch.flag_select = FLAG_HOLD;
    cfg_psel          = 1'b0;
    cfg_penable       = 1'b0;
    cfg_pwrite        = 1'b0;
    cfg_paddr         = '0;
    cfg_pwdata        = '0;
    press_level       = '0;
    for (int k = 0; k < NUM_KEYS; k++) press_left[k] = 0;
    detector_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows: reset values first, then short intervals sampled every tick
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == DIR_CFG_AT) apply_cfg(16'd3, 16'd2, 16'd1, 5'd1);
      send_item(dir_rows[i].cmd, dir_rows[i].levels, dir_rows[i].idx, dir_rows[i].sel,
                dir_rows[i].typed, dir_rows[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      lt = TIMER_W'($urandom_range(2, 10));
      dt = TIMER_W'($urandom_range(1, 6));
      rt = TIMER_W'($urandom_range(1, 4));
      dv = DIV_W'($urandom_range(1, 3));
      case (p)
        1: begin lt = 16'd1; dt = 16'd1; rt = 16'd1; dv = 5'd1; end
        2: begin lt = 16'hFFFF; dt = 16'hFFFF; rt = 16'hFFFF; dv = 5'd31; end
        // divider drops below a prescaler left high by the previous phase
        3: dv = 5'd2;
        // zero intervals and a zero divider
        4: begin lt = '0; dt = '0; rt = '0; dv = '0; end
        6: begin lt = 16'd4; dt = 16'hFFFF; rt = 16'd2; dv = 5'd1; end
        7: dv = 5'd5;
        default: ;
      endcase
      apply_cfg(lt, dt, rt, dv);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2) wait_results_idle();
        pick = $urandom_range(0, 99);
        if (pick < 30)
          send_item(CMD_CHECK, LEVEL_W'($urandom), IDX_W'($urandom_range(0, 7)),
                    SEL_W'($urandom_range(0, 7)), 1'b0, 1'b0);
        else if (pick < 38)
          send_item(CMD_TICK, LEVEL_W'($urandom_range(0, 255)), IDX_W'($urandom),
                    SEL_W'($urandom), 1'b0, 1'b0);
        else
          send_item(CMD_TICK, next_levels(), IDX_W'($urandom), SEL_W'($urandom),
                    1'b0, 1'b0);
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 30);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end else begin
          burst_left--;
        end
      end
    end

    wait_results_idle();
    if (fail_count == 0 && pending_flags.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: key_event_detector.f
+incdir+design
design/ked_pkg.sv
design/ked_in_if.sv
design/ked_out_if.sv
design/ked_regs.sv
design/ked_ctrl.sv
design/ked_datapath.sv
design/key_event_detector.sv
bench/key_event_detector_tb.sv
